// ----- rtl/core/uue_pkg.sv -----
`default_nettype none

package uue_pkg;

  localparam int LINE_BYTES_DEF = 45;

  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_BACKQUOTE = 8'h60;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;

  typedef enum logic [2:0] {
    S_FILL,
    S_LEN,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_CHAR,
    S_NL
  } state_t;

  typedef enum logic [1:0] {
    OSEL_LEN,
    OSEL_GRP,
    OSEL_NL
  } out_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     wr_en;
    logic     clr_fill;
    logic     grp_clr;
    logic     grp_step;
    logic [1:0] rd_off;
    logic     cap_en;
    logic [1:0] cap_off;
    logic     char_clr;
    logic     out_load;
    out_sel_t out_sel;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_at_end;
    logic grp_more;
    logic char_last;
    logic out_free;
  } ctl_sts_t;

  // 6-bit value to printable character, zero maps to backquote
  function automatic logic [7:0] enc6(input logic [5:0] v);
    logic [7:0] ch;
    if (v == 6'd0) ch = CHAR_BACKQUOTE;
    else ch = {2'b00, v} + CHAR_SPACE;
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/uuencode_line_encoder.sv -----
// uuencode line encoder: file bytes arrive one per beat on the slave side
// (tlast marks the last byte of the file) and are stored in a line buffer of
// LINE_BYTES entries. When the buffer fills, or the byte with tlast arrives,
// the block sends the encoded line on the master side: a length character,
// four characters per group of three bytes (a short last group is padded with
// zero bytes), and a newline that carries tlast. Characters are (v + space),
// with zero sent as backquote. Input is taken one byte per cycle while a line
// fills; during emission no input is taken. Emitting a line sends the length
// character, then for each group reads its bytes through the single
// registered read port of the line memory before sending its characters
// through the output register, and then sends the newline. The line memory
// needs no clearing pass after reset.
`default_nettype none

module uuencode_line_encoder #(
  parameter int LINE_BYTES = uue_pkg::LINE_BYTES_DEF  // 3 to 63
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input beats
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // final_byte
  // output beats
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic            m_tlast    // line_done
);

  uue_pkg::ctl_cmd_t cmd;
  uue_pkg::ctl_sts_t sts;

  // sequencer: fill, length char, per-group read and send, newline
  uue_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // line memory, counters, group word and output register
  uue_dpath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // the final byte always starts a flush, so no more input is taken next cycle
  a_flush_after_final: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after the final byte");

  // the end-of-line marker only rides on the newline character
  a_done_is_newline: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == uue_pkg::CHAR_NEWLINE)
    else $error("line_done on a character other than newline");

  // the line memory is written only on an accepted input beat
  a_write_on_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> s_tvalid && s_tready)
    else $error("line memory written without an input beat");

  // no character is loaded while an input beat is being taken
  a_no_emit_while_fill: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.out_load)
    else $error("character loaded during line fill");

endmodule

`default_nettype wire

// ----- rtl/core/uue_ram.sv -----
`default_nettype none

module uue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = uue_pkg::LINE_BYTES_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/uue_ctrl.sv -----
`default_nettype none

module uue_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic               s_tlast,
  input  wire uue_pkg::ctl_sts_t  sts,
  output logic                    s_tready,
  output uue_pkg::ctl_cmd_t       cmd
);

  uue_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uue_pkg::S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      uue_pkg::S_FILL: begin
        if (s_tvalid && (s_tlast || sts.fill_at_end)) state_next = uue_pkg::S_LEN;
      end
      uue_pkg::S_LEN: begin
        if (sts.out_free) state_next = uue_pkg::S_RD0;
      end
      uue_pkg::S_RD0: state_next = uue_pkg::S_RD1;
      uue_pkg::S_RD1: state_next = uue_pkg::S_RD2;
      uue_pkg::S_RD2: state_next = uue_pkg::S_RD3;
      uue_pkg::S_RD3: state_next = uue_pkg::S_CHAR;
      uue_pkg::S_CHAR: begin
        if (sts.out_free && sts.char_last) begin
          state_next = sts.grp_more ? uue_pkg::S_RD0 : uue_pkg::S_NL;
        end
      end
      uue_pkg::S_NL: begin
        if (sts.out_free) state_next = uue_pkg::S_FILL;
      end
      default: state_next = uue_pkg::S_FILL;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd.wr_en    = 1'b0;
    cmd.clr_fill = 1'b0;
    cmd.grp_clr  = 1'b0;
    cmd.grp_step = 1'b0;
    cmd.rd_off   = 2'd0;
    cmd.cap_en   = 1'b0;
    cmd.cap_off  = 2'd0;
    cmd.char_clr = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_sel  = uue_pkg::OSEL_LEN;
    unique case (state)
      uue_pkg::S_FILL: begin
        s_tready  = 1'b1;
        cmd.wr_en = s_tvalid;
      end
      uue_pkg::S_LEN: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = uue_pkg::OSEL_LEN;
        cmd.grp_clr  = 1'b1;
      end
      uue_pkg::S_RD0: begin
        cmd.rd_off = 2'd0;
      end
      uue_pkg::S_RD1: begin
        cmd.rd_off  = 2'd1;
        cmd.cap_en  = 1'b1;
        cmd.cap_off = 2'd0;
      end
      uue_pkg::S_RD2: begin
        cmd.rd_off  = 2'd2;
        cmd.cap_en  = 1'b1;
        cmd.cap_off = 2'd1;
      end
      uue_pkg::S_RD3: begin
        cmd.cap_en   = 1'b1;
        cmd.cap_off  = 2'd2;
        cmd.char_clr = 1'b1;
      end
      uue_pkg::S_CHAR: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = uue_pkg::OSEL_GRP;
        cmd.grp_step = sts.out_free && sts.char_last && sts.grp_more;
      end
      uue_pkg::S_NL: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = uue_pkg::OSEL_NL;
        cmd.clr_fill = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/uue_dpath.sv -----
`default_nettype none

module uue_dpath #(
  parameter int LINE_BYTES = uue_pkg::LINE_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire uue_pkg::ctl_cmd_t cmd,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              m_tready,
  output uue_pkg::ctl_sts_t      sts,
  output logic                   m_tvalid,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast
);

  localparam int CNT_W  = $clog2(LINE_BYTES + 1);
  localparam int ADDR_W = $clog2(LINE_BYTES);
  localparam int IDX_W  = CNT_W + 1;

  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  grp;
  logic [23:0]       word;
  logic [1:0]        char_cnt;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cap_idx;
  logic              rd_ok;
  logic              cap_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rdata;
  logic [7:0]        out_char;

  uue_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (fill[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // bytes past the end of the line read as zero
  assign rd_idx  = {1'b0, grp} + IDX_W'(cmd.rd_off);
  assign rd_ok   = rd_idx < {1'b0, fill};
  assign rd_addr = rd_ok ? rd_idx[ADDR_W-1:0] : '0;
  assign cap_idx = {1'b0, grp} + IDX_W'(cmd.cap_off);
  assign cap_ok  = cap_idx < {1'b0, fill};

  assign sts.fill_at_end = (fill == CNT_W'(LINE_BYTES - 1));
  assign sts.grp_more    = ({1'b0, grp} + IDX_W'(3)) < {1'b0, fill};
  assign sts.char_last   = (char_cnt == 2'd3);
  assign sts.out_free    = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.clr_fill) begin
      fill <= '0;
    end else if (cmd.wr_en) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grp_clr) begin
      grp <= '0;
    end else if (cmd.grp_step) begin
      grp <= grp + CNT_W'(3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.char_clr) begin
      char_cnt <= 2'd0;
    end else if (cmd.out_load && cmd.out_sel == uue_pkg::OSEL_GRP) begin
      char_cnt <= char_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      word <= {word[15:0], (cap_ok ? rdata : 8'h00)};
    end else if (cmd.out_load && cmd.out_sel == uue_pkg::OSEL_GRP) begin
      word <= {word[17:0], 6'd0};
    end
  end

  always_comb begin
    unique case (cmd.out_sel)
      uue_pkg::OSEL_LEN: out_char = uue_pkg::enc6(6'(fill));
      uue_pkg::OSEL_GRP: out_char = uue_pkg::enc6(word[23:18]);
      uue_pkg::OSEL_NL:  out_char = uue_pkg::CHAR_NEWLINE;
      default:           out_char = uue_pkg::CHAR_NEWLINE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= out_char;
      m_tlast <= (cmd.out_sel == uue_pkg::OSEL_NL);
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;

  localparam int LINE_LEN    = uue_pkg::LINE_BYTES_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_AT     = 200;   // output beat after which the receiver holds off
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 200;
  localparam int FILE_TARGET = 100;
  localparam int FILE_CAP    = 110;

  // one file byte with the idle cycles the sender waits before offering it
  typedef struct {
    logic [7:0]  data;
    logic        fin;
    int unsigned gap;
  } file_byte_t;

  // one encoded character as it should leave the block
  typedef struct packed {
    logic [7:0] ch;
    logic       done;
  } uu_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  uuencode_line_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // pending file bytes and the characters still owed by the block
  file_byte_t  file_q[$];
  uu_char_t    char_q[$];
  int unsigned bytes_total = 0;
  int unsigned bytes_taken = 0;
  int unsigned out_count = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  bit          in_beat = 1'b0;
  bit          out_beat = 1'b0;
  uu_char_t    want;

  // predictor state: bytes of the line being collected and how many are held
  logic [7:0]  line_buf [0:LINE_LEN-1];
  int          line_fill = 0;

  // 6-bit value to its printable character, zero goes to backquote
  function automatic logic [7:0] sixbit_char(input logic [5:0] v);
    return (v == 6'd0) ? uue_pkg::CHAR_BACKQUOTE : uue_pkg::CHAR_SPACE + {2'b00, v};
  endfunction

  function automatic void owe_char(input logic [7:0] ch, input logic done);
    uu_char_t c;
    c.ch = ch;
    c.done = done;
    char_q.push_back(c);
  endfunction

  // take one byte into the line; a full line or the final byte emits it
  function automatic void absorb_byte(input logic [7:0] b, input logic fin);
    int         n;
    logic [7:0] b0, b1, b2;
    if (line_fill < LINE_LEN) line_buf[line_fill] = b;
    line_fill = line_fill + 1;
    if (line_fill < LINE_LEN && !fin) return;
    n = line_fill;
    owe_char(sixbit_char(n[5:0]), 1'b0);
    for (int i = 0; i < n; i += 3) begin
      // short last group reads as zero bytes
      b0 = line_buf[i];
      b1 = (i + 1 < n) ? line_buf[i+1] : 8'h00;
      b2 = (i + 2 < n) ? line_buf[i+2] : 8'h00;
      owe_char(sixbit_char(b0[7:2]), 1'b0);
      owe_char(sixbit_char({b0[1:0], b1[7:4]}), 1'b0);
      owe_char(sixbit_char({b1[3:0], b2[7:6]}), 1'b0);
      owe_char(sixbit_char(b2[5:0]), 1'b0);
    end
    owe_char(uue_pkg::CHAR_NEWLINE, 1'b1);
    line_fill = 0;
  endfunction

  function automatic void add_byte(input logic [7:0] data, input logic fin,
                                   input int unsigned gap);
    file_byte_t fb;
    fb.data = data;
    fb.fin = fin;
    fb.gap = gap;
    file_q.push_back(fb);
    bytes_total++;
  endfunction

  // one file of len random bytes, the last one flagged final
  function automatic void add_file(input int len, input int unsigned gap_max);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       d = 8'h00;
        1:       d = 8'hff;
        default: d = 8'($urandom_range(0, 255));
      endcase
      add_byte(d, i == len - 1, $urandom_range(0, gap_max));
    end
  endfunction

  // sample both sides at the rising edge: check results, then predict
  always @(posedge clk) begin
    cycle_count++;
    in_beat = 1'b0;
    out_beat = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_beat = 1'b1;
        out_count++;
        if (char_q.size() == 0) begin
          $error("unexpected output beat: out_char %h line_done %b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = char_q.pop_front();
          if (m_tdata !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.done) begin
            $error("line_done: expected %b, actual %b", want.done, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        in_beat = 1'b1;
        bytes_taken++;
        absorb_byte(s_tdata, s_tlast);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sender: waits each byte's gap, then holds the beat until it is taken
  file_byte_t  cur;
  bit          have_cur = 1'b0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !in_beat)) begin
      if (!have_cur && file_q.size() > 0) begin
        cur = file_q.pop_front();
        have_cur = 1'b1;
        gap_left = cur.gap;
      end
      if (have_cur && gap_left == 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= cur.data;
        s_tlast <= cur.fin;
        have_cur = 1'b0;
      end else begin
        if (have_cur) gap_left--;
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each beat, quiet windows with no stall,
  // and one long hold-off so the block backs up into its input
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (out_beat) begin
        stall_left = ((out_count / 128) % 3 == 1) ? 0 : $urandom_range(0, 4);
        if (out_count == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  int flen;

  initial begin
    // directed: single bytes at the extremes, then short files of growing
    // length so every short last group and small length char shows up
    add_byte(8'h00, 1'b1, 0);
    add_byte(8'hff, 1'b1, 2);
    add_byte(8'hff, 1'b0, 0);
    add_byte(8'h00, 1'b1, 1);
    add_byte(8'h00, 1'b0, 0);
    add_byte(8'hff, 1'b0, 3);
    add_byte(8'h80, 1'b1, 0);
    add_byte(8'h55, 1'b0, 4);
    add_byte(8'haa, 1'b0, 0);
    add_byte(8'h01, 1'b0, 0);
    add_byte(8'hfe, 1'b1, 1);
    add_byte(8'h01, 1'b0, 0);
    add_byte(8'h02, 1'b0, 0);
    add_byte(8'h03, 1'b0, 2);
    add_byte(8'h04, 1'b0, 0);
    add_byte(8'h05, 1'b1, 0);
    add_byte(8'hfc, 1'b0, 0);
    add_byte(8'h03, 1'b0, 1);
    add_byte(8'h3f, 1'b0, 0);
    add_byte(8'hc0, 1'b0, 0);
    add_byte(8'h0f, 1'b0, 4);
    add_byte(8'hf0, 1'b1, 0);

    // final on a full line
    add_file(LINE_LEN, 4);
    // random files up to about a hundred bytes in all
    while (bytes_total < FILE_TARGET) begin
      case ($urandom_range(0, 4))
        0:       flen = LINE_LEN;
        1:       flen = $urandom_range(LINE_LEN + 1, 2 * LINE_LEN + 5);
        default: flen = $urandom_range(1, LINE_LEN - 1);
      endcase
      if (bytes_total + flen > FILE_CAP) flen = FILE_CAP - bytes_total;
      add_file(flen, $urandom_range(0, 1) ? 4 : 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (bytes_taken == bytes_total);
    while (char_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- uuencode_line_encoder.f -----
rtl/core/uue_pkg.sv
rtl/core/uue_ram.sv
rtl/core/uue_ctrl.sv
rtl/core/uue_dpath.sv
rtl/core/uuencode_line_encoder.sv
tb/sv/tb_top.sv
